// ===== rtl/core/lzw_byte_compressor_macros.svh =====
// Assertion macros shared by the LZW compressor RTL.
// No dependencies; defining NO_ASSERTIONS compiles them away.
`ifndef LZW_BYTE_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LZW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LZW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lzwc_pkg.sv =====
// Types, constants and hash function for the LZW compressor.
// No dependencies.
package lzwc_pkg;
    localparam int CODE_BITS  = 12;
    localparam int ALPHA_SIZE = 256;
    localparam int KEY_W      = CODE_BITS + 8;
    localparam int HBITS      = CODE_BITS + 1;
    localparam int NEXT_W     = CODE_BITS + 1;
    localparam int LIMIT_W    = 13;
    localparam int CMP_W      = (NEXT_W > LIMIT_W) ? NEXT_W : LIMIT_W;
    localparam int NCODES     = 1 << CODE_BITS;
    localparam int HSIZE      = 1 << HBITS;
    localparam int ENT_W      = KEY_W + HBITS;
    localparam int HI_W       = KEY_W - HBITS;

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [HBITS-1:0]     t_slot;
    typedef logic [NEXT_W-1:0]    t_next;
    typedef logic [LIMIT_W-1:0]   t_limit;

    typedef struct packed {
        logic load;
        logic first;
        logic clr_step;
        logic cand_lat;
        logic probe_next;
        logic hit;
        logic miss;
        logic emit_pre;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic prefix_valid;
        logic clr_done;
        logic out_free;
        logic match;
        logic slot_valid;
        logic eom;
    } t_stat;

    function automatic t_slot hash_key(t_key k);
        t_slot hi;
        hi = HBITS'(k[KEY_W-1:HBITS]);
        return k[HBITS-1:0] ^ hi ^ (hi << (HBITS - HI_W));
    endfunction
endpackage

// ===== rtl/core/lzwc_ifs.sv =====
// Request and result channel interfaces of the LZW compressor.
// Depends on lzwc_pkg.
interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source(output valid, data_byte, end_of_message, input ready);
    modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface lzwc_out_if import lzwc_pkg::*; ;
    logic  valid;
    logic  ready;
    t_code code;
    logic  last_of_run;
    logic  message_done;
    modport source(output valid, code, last_of_run, message_done, input ready);
    modport sink(input valid, code, last_of_run, message_done, output ready);
endinterface

// ===== rtl/core/lzwc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/lzwc_ctrl.sv =====
// Sequencer of the LZW compressor: clear pass, probe loop, code emission.
// Depends on lzwc_pkg.
module lzwc_ctrl import lzwc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_eom,
    output logic  o_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_ENT   = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_EMIT1 = 7'b0100000,
        S_EMIT2 = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.prefix_valid) begin
                        o_cmd.first = 1'b1;
                        n_state = i_eom ? S_EMIT2 : S_IDLE;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_SLOT: n_state = S_ENT;
            S_ENT: begin
                o_cmd.cand_lat = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state = i_stat.eom ? S_EMIT2 : S_IDLE;
                end else if (i_stat.slot_valid) begin
                    // occupied by another pair: linear probe
                    o_cmd.probe_next = 1'b1;
                    n_state = S_SLOT;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pre = 1'b1;
                    n_state = i_stat.eom ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ===== rtl/core/lzwc_dp.sv =====
// Datapath of the LZW compressor: hash slot table, dictionary, prefix, output register.
// Depends on lzwc_pkg, lzwc_ram and the assertion macros.
`include "lzw_byte_compressor_macros.svh"
module lzwc_dp import lzwc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_data_byte,
    input  logic       i_eom,
    input  logic       i_cfg_we,
    input  t_limit     i_cfg_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_code      o_code,
    output logic       o_last,
    output logic       o_done
);
    logic [7:0] r_byte;
    logic       r_eom;
    t_key       r_key;
    t_slot      r_slot;
    t_code      r_cand;
    t_code      r_prefix;
    logic       r_prefix_valid;
    t_next      r_next;
    t_limit     r_limit;
    t_slot      r_clr;
    logic       r_out_valid;
    t_code      r_out_code;
    logic       r_out_last;
    logic       r_out_done;

    t_code             slot_rdata;
    logic [ENT_W-1:0]  ent_rdata;
    t_key              ent_key;
    t_slot             ent_slot;
    logic              add_ok;
    logic              slot_valid;
    logic              out_free;
    logic              emit;

    assign ent_key  = ent_rdata[ENT_W-1:HBITS];
    assign ent_slot = ent_rdata[HBITS-1:0];
    assign add_ok   = (CMP_W'(r_next) < CMP_W'(r_limit)) && (r_next < NEXT_W'(NCODES));
    // a slot counts only if its code is live in this message and points back here
    assign slot_valid = (NEXT_W'(r_cand) >= NEXT_W'(ALPHA_SIZE))
                        && (NEXT_W'(r_cand) < r_next) && (ent_slot == r_slot);
    assign out_free = !r_out_valid || i_ready;
    assign emit     = i_cmd.emit_pre || i_cmd.emit_last;

    lzwc_ram #(.WIDTH(CODE_BITS), .DEPTH(HSIZE)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_step || (i_cmd.miss && add_ok)),
        .i_waddr (i_cmd.clr_step ? r_clr : r_slot),
        .i_wdata (i_cmd.clr_step ? t_code'(0) : r_next[CODE_BITS-1:0]),
        .i_raddr (r_slot),
        .o_rdata (slot_rdata)
    );

    lzwc_ram #(.WIDTH(ENT_W), .DEPTH(NCODES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.miss && add_ok),
        .i_waddr (r_next[CODE_BITS-1:0]),
        .i_wdata ({r_key, r_slot}),
        .i_raddr (slot_rdata),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_valid <= 1'b0;
            r_prefix       <= '0;
            r_next         <= NEXT_W'(ALPHA_SIZE);
            r_limit        <= LIMIT_W'(4096);
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.first) begin
                r_prefix       <= t_code'(i_data_byte);
                r_prefix_valid <= 1'b1;
            end
            if (i_cmd.hit) r_prefix <= r_cand;
            if (i_cmd.miss && add_ok) r_next <= r_next + 1'b1;
            if (i_cmd.emit_pre) r_prefix <= t_code'(r_byte);
            if (i_cmd.emit_last) begin
                r_prefix_valid <= 1'b0;
                r_prefix       <= '0;
                r_next         <= NEXT_W'(ALPHA_SIZE);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_eom  <= i_eom;
            r_key  <= {r_prefix, i_data_byte};
            r_slot <= hash_key({r_prefix, i_data_byte});
        end
        if (i_cmd.probe_next) r_slot <= r_slot + 1'b1;
        if (i_cmd.cand_lat) r_cand <= slot_rdata;
        if (emit) begin
            r_out_code <= r_prefix;
            r_out_last <= i_cmd.emit_last || !r_eom;
            r_out_done <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_stat              = '0;
        o_stat.prefix_valid = r_prefix_valid;
        o_stat.clr_done     = &r_clr;
        o_stat.out_free     = out_free;
        o_stat.slot_valid   = slot_valid;
        o_stat.match        = slot_valid && (ent_key == r_key);
        o_stat.eom          = r_eom;
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;

    `LZW_ASSERT_IMP(a_next_range, i_clk, i_rst_n, 1'b1,
        (r_next >= NEXT_W'(ALPHA_SIZE)) && (r_next <= NEXT_W'(NCODES)),
        "next code out of range")
    `LZW_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, emit, out_free,
        "code emitted into a full output register")
    `LZW_ASSERT_NXT(a_done_clears, i_clk, i_rst_n, i_cmd.emit_last,
        !r_prefix_valid && (r_next == NEXT_W'(ALPHA_SIZE)),
        "dictionary not cleared after final code")
endmodule

// ===== rtl/core/lzw_byte_compressor.sv =====
// LZW byte compressor, 12-bit codes, hashed dictionary with linear probing.
// Per byte: load, slot table read, dictionary read, then check; an extra probe repeats
// both reads and the check, and each emitted code adds an emit state; the registered reads set this loop.
// Output register lets the next request enter while a code waits downstream.
// Synchronous active-low reset, then a clear of all 8192 slot table entries (no requests taken).
// Depends on lzwc_pkg, lzwc_ifs, lzwc_ctrl, lzwc_dp.
module lzw_byte_compressor import lzwc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lzwc_in_if.sink           i_req,
    lzwc_out_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  t_limit            i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    lzwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_eom   (i_req.end_of_message),
        .o_ready (i_req.ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    lzwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data_byte (i_req.data_byte),
        .i_eom       (i_req.end_of_message),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_code      (o_rsp.code),
        .o_last      (o_rsp.last_of_run),
        .o_done      (o_rsp.message_done)
    );
endmodule

// ===== tb/lzwc_checker.sv =====
// Checker for the LZW byte compressor: watches request, result and register ports,
// predicts the emitted codes and compares them. Depends on lzwc_pkg and lzwc_ifs.
`timescale 1ns / 100ps

module lzwc_checker import lzwc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lzwc_in_if     req,
    lzwc_out_if    rsp,
    input  logic   i_cfg_we,
    input  t_limit i_cfg_data,
    output int     o_errors,
    output int     o_pending
);
    typedef struct {
        t_code code;
        logic  last;
        logic  done;
    } t_code_word;

    t_code_word code_q[$];
    int         pair_code[int];   // {prefix, byte} -> assigned code
    t_code      prefix;
    bit         prefix_vld;
    int         next_code;
    int         limit;

    initial begin
        o_errors   = 0;
        prefix     = '0;
        prefix_vld = 0;
        next_code  = ALPHA_SIZE;
        limit      = 4096;
    end

    assign o_pending = code_q.size();

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_errors++;
    endtask

    task automatic push_code(input t_code c, input logic done);
        t_code_word w;
        w.code = c;
        w.last = 0;
        w.done = done;
        code_q.push_back(w);
    endtask

    // one request -> zero, one or two expected codes
    task automatic compress_byte(input logic [7:0] b, input logic eom);
        int key;
        int eff;
        int n_before;
        n_before = code_q.size();
        if (!prefix_vld) begin
            prefix     = t_code'(b);
            prefix_vld = 1;
        end else begin
            key = {prefix, b};
            if (pair_code.exists(key)) begin
                prefix = t_code'(pair_code[key]);
            end else begin
                eff = (limit > NCODES) ? NCODES : limit;
                push_code(prefix, 0);
                if (next_code < eff) begin
                    pair_code[key] = next_code;
                    next_code++;
                end
                prefix = t_code'(b);
            end
        end
        if (eom) begin
            push_code(prefix, 1);
            pair_code.delete();
            next_code  = ALPHA_SIZE;
            prefix_vld = 0;
            prefix     = '0;
        end
        if (code_q.size() > n_before)
            code_q[code_q.size()-1].last = 1;
    endtask

    always @(posedge i_clk) begin
        t_code_word w;
        if (i_rst_n) begin
            if (i_cfg_we)
                limit = int'(i_cfg_data);
            if (req.valid && req.ready)
                compress_byte(req.data_byte, req.end_of_message);
            if (rsp.valid && rsp.ready) begin
                if (code_q.size() == 0) begin
                    report($sformatf("unexpected code %0d", rsp.code));
                end else begin
                    w = code_q.pop_front();
                    if (rsp.code !== w.code)
                        report($sformatf("code %0d, want %0d", rsp.code, w.code));
                    if (rsp.last_of_run !== w.last)
                        report($sformatf("last_of_run %b, want %b on code %0d",
                                         rsp.last_of_run, w.last, w.code));
                    if (rsp.message_done !== w.done)
                        report($sformatf("message_done %b, want %b on code %0d",
                                         rsp.message_done, w.done, w.code));
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the LZW compressor testbench: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on lzwc_pkg, lzwc_ifs, lzwc_checker and the RTL.
`timescale 1ns / 100ps

module tb_top import lzwc_pkg::*; ();
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 60;

    logic   i_clk = 0;
    logic   i_rst_n = 0;
    logic   cfg_we = 0;
    t_limit cfg_data = '0;
    int     errors;
    int     pending;
    int     n_sent = 0;
    int     cycles = 0;
    bit     burst_done = 0;

    lzwc_in_if  req_ch();
    lzwc_out_if rsp_ch();

    lzw_byte_compressor uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch.sink),
        .o_rsp     (rsp_ch.source),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    lzwc_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit quiet();
        return n_sent >= 500 && n_sent < 620;
    endfunction

    // result side: random stalls, one long hold-off while requests keep coming
    initial begin
        rsp_ch.ready <= 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!burst_done && n_sent >= 300) begin
                burst_done = 1;
                rsp_ch.ready <= 0;
                repeat (250) @(posedge i_clk);
            end
            rsp_ch.ready <= quiet() || ($urandom_range(0, 99) >= 11);
            @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while (!quiet() && $urandom_range(0, 99) < 11) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1;
        req_ch.data_byte      <= b;
        req_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_limit v);
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 0;
    endtask

    // random message; a small alphabet makes long matches and fills the table
    task automatic send_message(input int len);
        int alpha;
        int base;
        alpha = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : 256;
        base  = $urandom_range(0, 255);
        for (int i = 0; i < len; i++)
            send_byte(8'((base + $urandom_range(0, alpha - 1)) % 256), i == len - 1);
    endtask

    t_limit limits[8] = '{13'd257, 13'd256, 13'd8191, 13'd300, 13'd0,
                          13'd4096, 13'd600, 13'd4095};

    initial begin
        int goal;
        req_ch.valid          <= 0;
        req_ch.data_byte      <= '0;
        req_ch.end_of_message <= 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_limit(13'd4096);

        // directed: single-byte messages, extremes, repeats that hit
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        for (int i = 0; i < 8; i++)
            send_byte(8'hAA, i == 7);
        for (int i = 0; i < 8; i++)
            send_byte(8'(i[0] ? 8'h55 : 8'hFF), i == 7);
        drain();

        // no entries may be added below 257
        write_limit(13'd256);
        for (int i = 0; i < 6; i++)
            send_byte(8'h0F, i == 5);
        drain();

        foreach (limits[p]) begin
            write_limit(limits[p]);
            goal = n_sent + 82;
            while (n_sent < goal)
                send_message(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                         : $urandom_range(5, 60));
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
